/* sv/work_stealing_deque_macros.svh */
// Assertion macros for the work-stealing deque controller.
`ifndef WORK_STEALING_DEQUE_MACROS_SVH
`define WORK_STEALING_DEQUE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define WSD_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deque check failed");

// When the trigger is seen, the condition holds in the next cycle.
`define WSD_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("deque check failed");

`endif

/* sv/wsd_pkg.sv */
// Shared types, constants and position helpers for the work-stealing deque.
package wsd_pkg;

  localparam int CAPACITY = 16;
  localparam int TWO_CAP  = 2 * CAPACITY;
  localparam int PTR_W    = $clog2(TWO_CAP);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HANDLE_W = 64;
  localparam int OCC_W    = 5;

  typedef logic [1:0]       kind_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  localparam kind_t KIND_PUSH  = 2'd0;
  localparam kind_t KIND_POP   = 2'd1;
  localparam kind_t KIND_STEAL = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    idx_t addr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic got;
    logic rejected;
    occ_t occ;
  } rsp_t;

  function automatic ptr_t pos_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(TWO_CAP - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic ptr_t pos_dec(input ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = ptr_t'(TWO_CAP - 1);
    end else begin
      r = p - ptr_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t slot_of(input ptr_t p);
    ptr_t s;
    if (p >= ptr_t'(CAPACITY)) begin
      s = p - ptr_t'(CAPACITY);
    end else begin
      s = p;
    end
    return idx_t'(s);
  endfunction

  function automatic ptr_t count_of(input ptr_t t, input ptr_t h);
    logic [PTR_W:0] wide;
    if (t >= h) begin
      wide = {1'b0, t} - {1'b0, h};
    end else begin
      wide = {1'b0, t} + (PTR_W+1)'(TWO_CAP) - {1'b0, h};
    end
    return wide[PTR_W-1:0];
  endfunction

endpackage

/* sv/wsd_ram.sv */
// Single-port synchronous RAM with a registered read, used for task storage.
module wsd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/wsd_ctrl.sv */
// Head and tail pointer control, slot addressing and result flags of the deque.
`include "work_stealing_deque_macros.svh"

module wsd_ctrl import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  kind_t    kind,
  output logic     busy,
  output mem_req_t mem_req,
  output rsp_t     rsp
);

  ptr_t head, head_next;
  ptr_t tail, tail_next;
  ptr_t cnt;
  rsp_t rsp_next;
  logic accept;

  assign accept = start && !busy;
  assign cnt    = count_of(tail, head);

  always_comb begin
    head_next         = head;
    tail_next         = tail;
    mem_req           = '0;
    rsp_next          = '0;
    rsp_next.valid    = accept;
    if (accept) begin
      case (kind)
        KIND_PUSH: begin
          if (cnt >= ptr_t'(CAPACITY)) begin
            rsp_next.rejected = 1'b1;
          end else begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = slot_of(tail);
            tail_next     = pos_inc(tail);
          end
        end
        KIND_POP: begin
          if (cnt != '0) begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = slot_of(pos_dec(tail));
            rsp_next.got  = 1'b1;
            if (cnt == ptr_t'(1)) begin
              head_next = pos_inc(head);
              tail_next = pos_inc(head);
            end else begin
              tail_next = pos_dec(tail);
            end
          end
        end
        KIND_STEAL: begin
          if (cnt != '0) begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = slot_of(head);
            rsp_next.got  = 1'b1;
            head_next     = pos_inc(head);
          end
        end
        default: begin
        end
      endcase
    end
    rsp_next.occ = occ_t'(count_of(tail_next, head_next));
  end

  always_ff @(posedge clk) begin
    rsp.got      <= rsp_next.got;
    rsp.rejected <= rsp_next.rejected;
    rsp.occ      <= rsp_next.occ;
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      rsp.valid <= rsp_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  `WSD_NEXT(a_result_follows, accept, rsp.valid)
  `WSD_NEXT(a_no_spurious_result, !accept, !rsp.valid)
  `WSD_HOLDS(a_flags_exclusive, !(rsp.valid && rsp.got && rsp.rejected))
  `WSD_HOLDS(a_count_bounded, count_of(tail, head) <= ptr_t'(CAPACITY))
  `WSD_HOLDS(a_single_access, !(mem_req.wr_en && mem_req.rd_en))

endmodule

/* sv/work_stealing_deque.sv */
// Top level of the work-stealing task deque.
//
// Operations arrive on the command channel: start with kind and task_handle,
// taken at a rising edge where start is high and busy is low. A push stores
// task_handle at the tail, a pop takes the newest task from the tail and a
// steal takes the oldest task from the head. Unused kind codes do nothing.
// Every accepted operation yields one result beat, marked by done for a
// single cycle, in the cycle after the operation was accepted. The beat
// carries task_out (zero when nothing was taken), got_task, push_rejected for
// a push against a full deque, and occupancy after the operation.
// One operation is taken every cycle while busy is low; pointers update at
// acceptance; the task storage RAM is accessed at most once, reads registered.
// Synchronous reset empties the deque; busy is high for one cycle after reset.
// The receiver cannot stall, so results must be captured in the done cycle.
module work_stealing_deque import wsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic [HANDLE_W-1:0] task_handle,
  output logic                done,
  output logic [HANDLE_W-1:0] task_out,
  output logic                got_task,
  output logic                push_rejected,
  output logic [OCC_W-1:0]    occupancy
);

  mem_req_t            mem_req;
  rsp_t                rsp;
  logic [HANDLE_W-1:0] rdata;

  wsd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .kind    (kind),
    .busy    (busy),
    .mem_req (mem_req),
    .rsp     (rsp)
  );

  wsd_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (HANDLE_W)
  ) u_ram (
    .clk   (clk),
    .wr_en (mem_req.wr_en),
    .rd_en (mem_req.rd_en),
    .addr  (mem_req.addr),
    .wdata (task_handle),
    .rdata (rdata)
  );

  assign done          = rsp.valid;
  assign got_task      = rsp.got;
  assign push_rejected = rsp.rejected;
  assign occupancy     = rsp.occ;
  assign task_out      = rsp.got ? rdata : '0;

endmodule

/* tb/work_stealing_deque_test.sv */
// Self-checking testbench for the work-stealing task deque: directed table, then random traffic.
`timescale 1ns / 1ps

module work_stealing_deque_test;
  import wsd_pkg::*;

  localparam kind_t KIND_NONE  = 2'd3;
  localparam int    RANDOM_OPS = 1425;
  localparam int    IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [HANDLE_W-1:0] task_out;
    logic                got;
    logic                rejected;
    occ_t                occ;
  } outcome_t;

  typedef struct {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic                typed;
    outcome_t            want;
  } op_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  kind_t               kind = KIND_PUSH;
  logic [HANDLE_W-1:0] task_handle = '0;
  logic                busy;
  logic                done;
  logic [HANDLE_W-1:0] task_out;
  logic                got_task;
  logic                push_rejected;
  logic [OCC_W-1:0]    occupancy;

  // Expected outcome typed into the table travels with the operation.
  logic     row_typed = 1'b0;
  outcome_t row_want = '0;

  logic [HANDLE_W-1:0] task_store [CAPACITY];
  int                  head_at;
  int                  tail_at;
  outcome_t            awaited_outcomes [$];
  op_row_t             directed_ops [$];

  int errors;
  int idle_cycles;
  int beats_checked;
  int ops_taken;
  int pushes_stored;
  int pushes_refused;
  int tasks_handed_out;
  int empty_takes;
  int peak_fill;
  int burst_left;
  bit quiet;

  work_stealing_deque dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .task_handle   (task_handle),
    .done          (done),
    .task_out      (task_out),
    .got_task      (got_task),
    .push_rejected (push_rejected),
    .occupancy     (occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic int fill_level();
    return (tail_at - head_at + TWO_CAP) % TWO_CAP;
  endfunction

  // Applies one operation to the shadow deque and returns the beat it should produce.
  function automatic outcome_t deque_outcome(input kind_t k, input logic [HANDLE_W-1:0] h);
    outcome_t r;
    int       held;
    r = '0;
    held = fill_level();
    case (k)
      KIND_PUSH: begin
        if (held >= CAPACITY) begin
          r.rejected = 1'b1;
        end else begin
          task_store[tail_at % CAPACITY] = h;
          tail_at = (tail_at + 1) % TWO_CAP;
        end
      end
      KIND_POP: begin
        if (held > 0) begin
          tail_at = (tail_at + TWO_CAP - 1) % TWO_CAP;
          r.task_out = task_store[tail_at % CAPACITY];
          r.got = 1'b1;
          if (held == 1) begin
            head_at = (head_at + 1) % TWO_CAP;
            tail_at = head_at;
          end
        end
      end
      KIND_STEAL: begin
        if (held > 0) begin
          r.task_out = task_store[head_at % CAPACITY];
          r.got = 1'b1;
          head_at = (head_at + 1) % TWO_CAP;
        end
      end
      default: begin
      end
    endcase
    r.occ = occ_t'(fill_level());
    return r;
  endfunction

  function automatic void add_row(input kind_t k, input logic [HANDLE_W-1:0] h,
                                  input logic typed, input logic [HANDLE_W-1:0] t,
                                  input logic g, input logic rj, input int occ);
    op_row_t row;
    row.kind = k;
    row.handle = h;
    row.typed = typed;
    row.want = '{task_out: t, got: g, rejected: rj, occ: occ_t'(occ)};
    directed_ops.push_back(row);
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t seen;
    if (rst) begin
      head_at = 0;
      tail_at = 0;
      awaited_outcomes.delete();
      idle_cycles = 0;
    end else begin
      if (done || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (done) begin
        seen = '{task_out: task_out, got: got_task, rejected: push_rejected, occ: occupancy};
        if (awaited_outcomes.size() == 0) begin
          flag_mismatch($sformatf("result beat with no operation outstanding: %p", seen));
        end else begin
          want = awaited_outcomes.pop_front();
          beats_checked++;
          if (seen.task_out !== want.task_out) begin
            flag_mismatch($sformatf("beat %0d task_out %h, expected %h",
                                    beats_checked, seen.task_out, want.task_out));
          end
          if (seen.got !== want.got) begin
            flag_mismatch($sformatf("beat %0d got_task %b, expected %b",
                                    beats_checked, seen.got, want.got));
          end
          if (seen.rejected !== want.rejected) begin
            flag_mismatch($sformatf("beat %0d push_rejected %b, expected %b",
                                    beats_checked, seen.rejected, want.rejected));
          end
          if (seen.occ !== want.occ) begin
            flag_mismatch($sformatf("beat %0d occupancy %0d, expected %0d",
                                    beats_checked, seen.occ, want.occ));
          end
        end
      end
      if (start && !busy) begin
        want = deque_outcome(kind, task_handle);
        if (row_typed) begin
          want = row_want;
        end
        awaited_outcomes.push_back(want);
        ops_taken++;
        if (kind == KIND_PUSH) begin
          if (want.rejected) begin
            pushes_refused++;
          end else begin
            pushes_stored++;
          end
        end else if (kind == KIND_POP || kind == KIND_STEAL) begin
          if (want.got) begin
            tasks_handed_out++;
          end else begin
            empty_takes++;
          end
        end
        if (fill_level() > peak_fill) begin
          peak_fill = fill_level();
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    $display("Timed out after %0d cycles without a beat", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Holds one operation on the command port until the deque takes it.
  task automatic issue_op(input kind_t k, input logic [HANDLE_W-1:0] h,
                          input logic typed, input outcome_t want);
    start <= 1'b1;
    kind <= k;
    task_handle <= h;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_pause();
    int gap;
    if (quiet) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 6);
    start <= 1'b0;
    kind <= kind_t'($urandom_range(0, 3));
    task_handle <= {$urandom, $urandom};
    row_typed <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(0, 24);
  endtask

  initial begin
    int                  i;
    int                  n;
    int                  seg_left;
    int                  push_pct;
    int                  pick;
    kind_t               k;
    logic [HANDLE_W-1:0] h;

    errors = 0;
    burst_left = 0;
    quiet = 1'b0;
    peak_fill = 0;

    add_row(KIND_POP,   '0, 1'b1, '0, 1'b0, 1'b0, 0);
    add_row(KIND_STEAL, '0, 1'b1, '0, 1'b0, 1'b0, 0);
    add_row(KIND_NONE,  '1, 1'b1, '0, 1'b0, 1'b0, 0);
    add_row(KIND_PUSH,  '1, 1'b1, '0, 1'b0, 1'b0, 1);
    add_row(KIND_POP,   '0, 1'b1, '1, 1'b1, 1'b0, 0);
    add_row(KIND_PUSH,  '0, 1'b1, '0, 1'b0, 1'b0, 1);
    add_row(KIND_STEAL, '1, 1'b1, '0, 1'b1, 1'b0, 0);
    for (i = 0; i < CAPACITY; i++) begin
      add_row(KIND_PUSH, {16{4'(i)}}, 1'b1, '0, 1'b0, 1'b0, i + 1);
    end
    add_row(KIND_PUSH,  '1, 1'b1, '0, 1'b0, 1'b1, CAPACITY);
    add_row(KIND_NONE,  '0, 1'b1, '0, 1'b0, 1'b0, CAPACITY);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[j]) begin
      issue_op(directed_ops[j].kind, directed_ops[j].handle,
               directed_ops[j].typed, directed_ops[j].want);
      sender_pause();
    end

    // Segments lean towards filling or draining so both ends are reached often.
    seg_left = 0;
    push_pct = 50;
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 90);
        push_pct = 15 + 15 * $urandom_range(0, 4);
        quiet = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        k = KIND_NONE;
      end else if (pick < 2 + push_pct) begin
        k = KIND_PUSH;
      end else if (pick[0]) begin
        k = KIND_POP;
      end else begin
        k = KIND_STEAL;
      end
      case ($urandom_range(0, 19))
        0:       h = '0;
        1:       h = '1;
        default: h = {$urandom, $urandom};
      endcase
      issue_op(k, h, 1'b0, '0);
      sender_pause();
    end
    start <= 1'b0;
    row_typed <= 1'b0;

    n = 0;
    while (awaited_outcomes.size() != 0 && n < 100) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
    if (awaited_outcomes.size() != 0) begin
      flag_mismatch($sformatf("%0d result beats never arrived", awaited_outcomes.size()));
    end

    $display("Ran %0d operations: %0d pushes stored, %0d refused when full, %0d tasks taken.",
             ops_taken, pushes_stored, pushes_refused, tasks_handed_out);
    $display("Takes on an empty deque: %0d; highest fill %0d of %0d; %0d beats checked.",
             empty_takes, peak_fill, CAPACITY, beats_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
